// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge out of reset.
`define OQR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("oqr check failed");
// Antecedent in one cycle, consequent in the next.
`define OQR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("oqr check failed");
`endif

// ===== rtl/core/oqr_pkg.sv =====
// Shared constants and types for the ordered ticket queue.
package oqr_pkg;
    localparam int MAX_IDS = 1024;
    localparam int ID_W    = $clog2(MAX_IDS);
    localparam int CNT_W   = ID_W + 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_IDS);
    localparam logic [ID_W-1:0]  LAST_ID = ID_W'(MAX_IDS - 1);

    typedef enum logic [1:0] {
        OP_ISSUE  = 2'd0,
        OP_SERVE  = 2'd1,
        OP_REMOVE = 2'd2,
        OP_MOVE   = 2'd3
    } op_t;

    typedef struct packed {
        logic clr;
        logic load;
        logic dec;
        logic ins;
        logic fin;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic need_ins;
        logic out_free;
    } stat_t;
endpackage

// ===== rtl/core/oqr_ram.sv =====
// Generic single write port RAM with registered read.
module oqr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/oqr_ctrl.sv =====
// Sequencer for the ordered ticket queue.
module oqr_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  oqr_pkg::stat_t stat,
    output oqr_pkg::cmd_t  cmd
);
    typedef enum logic [5:0] {
        ST_CLR  = 6'b000001,
        ST_IDLE = 6'b000010,
        ST_RD   = 6'b000100,
        ST_DEC  = 6'b001000,
        ST_INS  = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLR:
            begin
                cmd.clr = 1'b1;
                if (stat.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_DEC;
            end
            ST_DEC:
            begin
                cmd.dec    = 1'b1;
                state_next = stat.need_ins ? ST_INS : ST_FIN;
            end
            ST_INS:
            begin
                cmd.ins    = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cmd.fin = 1'b1;
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLR;
            end
        endcase
    end
endmodule

// ===== rtl/core/oqr_dp.sv =====
// Datapath: link, flag and free-stack memories, queue registers, result register.
module oqr_dp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  oqr_pkg::cmd_t             cmd,
    output oqr_pkg::stat_t            stat,
    input  logic [1:0]                op,
    input  logic [oqr_pkg::ID_W-1:0]  ticket,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      ok,
    output logic [oqr_pkg::ID_W-1:0]  result_id,
    output logic [oqr_pkg::CNT_W-1:0] length
);
    localparam int IW = oqr_pkg::ID_W;
    localparam int CW = oqr_pkg::CNT_W;

    oqr_pkg::op_t    op_reg;
    logic [IW-1:0]   tgt_reg, head_reg, head_next, tail_reg, tail_next, clr_reg;
    logic [CW-1:0]   qc_reg, qc_next, sc_reg, sc_next, mark_reg, mark_next;
    logic            okr_reg, okr_next;
    logic [IW-1:0]   rid_reg, rid_next;
    logic            ov_reg;
    logic            ok_o_reg;
    logic [IW-1:0]   rid_o_reg;
    logic [CW-1:0]   len_o_reg;

    logic            nx_we, pv_we, fl_we, st_we, fl_wd;
    logic [IW-1:0]   nx_wa, nx_wd, pv_wa, pv_wd, fl_wa, st_wa, st_wd;
    logic [IW-1:0]   nx_rd, pv_rd, st_rd;
    logic            fl_rd;
    logic [IW-1:0]   st_ra;

    logic [CW-1:0]   fresh, qc_less;
    logic            do_unl, do_app;
    logic [IW-1:0]   app_id;

    assign st_ra = IW'(sc_reg - CW'(1));

    oqr_ram #(.WIDTH(IW), .DEPTH(oqr_pkg::MAX_IDS)) u_next (
        .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(tgt_reg), .rdata(nx_rd));
    oqr_ram #(.WIDTH(IW), .DEPTH(oqr_pkg::MAX_IDS)) u_prev (
        .clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(tgt_reg), .rdata(pv_rd));
    oqr_ram #(.WIDTH(1), .DEPTH(oqr_pkg::MAX_IDS)) u_flag (
        .clk(clk), .we(fl_we), .waddr(fl_wa), .wdata(fl_wd), .raddr(tgt_reg), .rdata(fl_rd));
    oqr_ram #(.WIDTH(IW), .DEPTH(oqr_pkg::MAX_IDS)) u_stack (
        .clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(st_ra), .rdata(st_rd));

    // mark of all ones wraps to zero: first fresh ID
    assign fresh   = mark_reg + CW'(1);
    assign qc_less = qc_reg - CW'(1);

    always_comb
    begin
        do_unl = 1'b0;
        do_app = 1'b0;
        app_id = st_rd;
        unique case (op_reg)
            oqr_pkg::OP_ISSUE:
            begin
                if (sc_reg != '0)
                begin
                    do_app = 1'b1;
                end
                else if (fresh < oqr_pkg::MAX_CNT)
                begin
                    do_app = 1'b1;
                    app_id = IW'(fresh);
                end
            end
            oqr_pkg::OP_SERVE:  do_unl = (qc_reg != '0);
            oqr_pkg::OP_REMOVE: do_unl = fl_rd;
            oqr_pkg::OP_MOVE:   do_unl = fl_rd;
            default:            do_unl = 1'b0;
        endcase
    end

    assign stat.need_ins = (op_reg == oqr_pkg::OP_MOVE) && fl_rd;
    assign stat.out_free = !ov_reg || out_ready;
    assign stat.clr_done = (clr_reg == oqr_pkg::LAST_ID);

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        qc_next   = qc_reg;
        sc_next   = sc_reg;
        mark_next = mark_reg;
        okr_next  = okr_reg;
        rid_next  = rid_reg;
        nx_we = 1'b0; nx_wa = tgt_reg; nx_wd = head_reg;
        pv_we = 1'b0; pv_wa = tgt_reg; pv_wd = tail_reg;
        fl_we = 1'b0; fl_wa = tgt_reg; fl_wd = 1'b0;
        st_we = 1'b0; st_wa = IW'(sc_reg); st_wd = tgt_reg;
        if (cmd.clr)
        begin
            fl_we = 1'b1;
            fl_wa = clr_reg;
        end
        else if (cmd.dec)
        begin
            okr_next = do_app || do_unl;
            rid_next = '0;
            if (do_app)
            begin
                rid_next = app_id;
                if (sc_reg != '0)
                begin
                    sc_next = sc_reg - CW'(1);
                end
                else
                begin
                    mark_next = fresh;
                end
                fl_we = 1'b1; fl_wa = app_id; fl_wd = 1'b1;
                if (qc_reg == '0)
                begin
                    head_next = app_id;
                end
                else
                begin
                    nx_we = 1'b1; nx_wa = tail_reg; nx_wd = app_id;
                    pv_we = 1'b1; pv_wa = app_id;   pv_wd = tail_reg;
                end
                tail_next = app_id;
                qc_next   = qc_reg + CW'(1);
            end
            else if (do_unl)
            begin
                if (op_reg == oqr_pkg::OP_SERVE)
                begin
                    rid_next = tgt_reg;
                end
                if (tgt_reg == head_reg)
                begin
                    head_next = nx_rd;
                end
                else
                begin
                    nx_we = 1'b1; nx_wa = pv_rd; nx_wd = nx_rd;
                end
                if (tgt_reg == tail_reg)
                begin
                    tail_next = pv_rd;
                end
                else
                begin
                    pv_we = 1'b1; pv_wa = nx_rd; pv_wd = pv_rd;
                end
                qc_next = qc_less;
                if (qc_less == '0)
                begin
                    head_next = '0;
                    tail_next = '0;
                end
                // a moved ID keeps its flag; others return to the stack
                if (op_reg != oqr_pkg::OP_MOVE)
                begin
                    fl_we = 1'b1;
                    if (sc_reg < oqr_pkg::MAX_CNT)
                    begin
                        st_we   = 1'b1;
                        sc_next = sc_reg + CW'(1);
                    end
                end
            end
        end
        else if (cmd.ins)
        begin
            if (qc_reg == '0)
            begin
                tail_next = tgt_reg;
            end
            else
            begin
                pv_we = 1'b1; pv_wa = head_reg; pv_wd = tgt_reg;
                nx_we = 1'b1; nx_wa = tgt_reg;  nx_wd = head_reg;
            end
            head_next = tgt_reg;
            qc_next   = qc_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            qc_reg   <= '0;
            sc_reg   <= '0;
            mark_reg <= '1;
            clr_reg  <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            qc_reg   <= qc_next;
            sc_reg   <= sc_next;
            mark_reg <= mark_next;
            if (cmd.clr)
            begin
                clr_reg <= clr_reg + IW'(1);
            end
            if (cmd.fin && stat.out_free)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        okr_reg <= okr_next;
        rid_reg <= rid_next;
        if (cmd.load)
        begin
            op_reg  <= oqr_pkg::op_t'(op);
            tgt_reg <= (oqr_pkg::op_t'(op) == oqr_pkg::OP_SERVE) ? head_reg : ticket;
        end
        if (cmd.fin && stat.out_free)
        begin
            ok_o_reg  <= okr_reg;
            rid_o_reg <= rid_reg;
            len_o_reg <= qc_reg;
        end
    end

    assign out_valid = ov_reg;
    assign ok        = ok_o_reg;
    assign result_id = rid_o_reg;
    assign length    = len_o_reg;
endmodule

// ===== rtl/core/ordered_queue_with_id_recycling.sv =====
// Ordered ticket queue with ID recycling: top level.
// A transaction passes the read, decide, insert (move-to-front only) and finish
// states; finish waits for a free output. One transaction is in flight at a time,
// set by the dependent registered read, then write, of the link memories.
// Reset: async, active low; then a pass over all 1024 IDs clears the membership
// flags, during which in_ready stays low.
module ordered_queue_with_id_recycling (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                op,
    input  logic [oqr_pkg::ID_W-1:0]  ticket,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      ok,
    output logic [oqr_pkg::ID_W-1:0]  result_id,
    output logic [oqr_pkg::CNT_W-1:0] length
);
    oqr_pkg::cmd_t  cmd;
    oqr_pkg::stat_t stat;

    oqr_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .stat(stat), .cmd(cmd));

    oqr_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .op(op), .ticket(ticket),
        .out_valid(out_valid), .out_ready(out_ready), .ok(ok),
        .result_id(result_id), .length(length));
endmodule

// ===== rtl/core/oqr_checker.sv =====
// Port-level checker for the ordered ticket queue, bound to the top level.
`include "assert_macros.svh"
module oqr_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic                      ok,
    input logic [oqr_pkg::ID_W-1:0]  result_id,
    input logic [oqr_pkg::CNT_W-1:0] length
);
    `OQR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_id) && $stable(length))
    `OQR_ASSERT(a_fail_zero, (out_valid && !ok) |-> (result_id == '0))
    `OQR_ASSERT(a_len_max, out_valid |-> (length <= oqr_pkg::MAX_CNT))
    `OQR_ASSERT_NEXT(a_one_at_time, in_valid && in_ready, !in_ready)
endmodule

bind ordered_queue_with_id_recycling oqr_checker u_oqr_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .ok(ok),
    .result_id(result_id), .length(length));

// ===== sim/ordered_queue_with_id_recycling_test.sv =====
// Testbench for the ordered ticket queue: random and directed transactions.
`timescale 1ns / 100ps

module ordered_queue_with_id_recycling_test;
    localparam int RUN_LIMIT = 400000;

    typedef struct packed {
        logic [1:0]               op;
        logic [oqr_pkg::ID_W-1:0] ticket;
    } req_t;

    typedef struct packed {
        logic                      ok;
        logic [oqr_pkg::ID_W-1:0]  rid;
        logic [oqr_pkg::CNT_W-1:0] len;
    } resp_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [1:0] op;
    logic [oqr_pkg::ID_W-1:0] ticket;
    logic out_valid;
    logic out_ready;
    logic ok;
    logic [oqr_pkg::ID_W-1:0] result_id;
    logic [oqr_pkg::CNT_W-1:0] length;

    ordered_queue_with_id_recycling dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .op(op), .ticket(ticket),
        .out_valid(out_valid), .out_ready(out_ready),
        .ok(ok), .result_id(result_id), .length(length)
    );

    // predictor state
    logic [oqr_pkg::ID_W-1:0]  lnk_next [oqr_pkg::MAX_IDS];
    logic [oqr_pkg::ID_W-1:0]  lnk_prev [oqr_pkg::MAX_IDS];
    logic                      in_line [oqr_pkg::MAX_IDS];
    logic [oqr_pkg::ID_W-1:0]  spare_ids [oqr_pkg::MAX_IDS];
    int                        spare_cnt;
    logic [oqr_pkg::ID_W-1:0]  q_head;
    logic [oqr_pkg::ID_W-1:0]  q_tail;
    int                        q_len;
    int                        mark;     // -1 until the first fresh ID

    req_t  pending_reqs[$];
    resp_t awaited[$];

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  recv_hold;
    bit  in_taken;
    int  errors;
    int  cycles;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic void take_out(input logic [oqr_pkg::ID_W-1:0] id);
        logic [oqr_pkg::ID_W-1:0] p;
        logic [oqr_pkg::ID_W-1:0] n;
        p = lnk_prev[id];
        n = lnk_next[id];
        if (id == q_head)
            q_head = n;
        else
            lnk_next[p] = n;
        if (id == q_tail)
            q_tail = p;
        else
            lnk_prev[n] = p;
        in_line[id] = 1'b0;
        if (q_len > 0)
            q_len--;
        if (q_len == 0)
        begin
            q_head = '0;
            q_tail = '0;
        end
    endfunction

    function automatic void give_back(input logic [oqr_pkg::ID_W-1:0] id);
        if (spare_cnt < oqr_pkg::MAX_IDS)
        begin
            spare_ids[spare_cnt] = id;
            spare_cnt++;
        end
    endfunction

    function automatic resp_t ticket_outcome(input req_t r);
        resp_t res;
        res = '0;
        case (oqr_pkg::op_t'(r.op))
            oqr_pkg::OP_ISSUE:
            begin
                if (spare_cnt > 0 || mark < oqr_pkg::MAX_IDS - 1)
                begin
                    if (spare_cnt > 0)
                    begin
                        spare_cnt--;
                        res.rid = spare_ids[spare_cnt];
                    end
                    else
                    begin
                        mark++;
                        res.rid = oqr_pkg::ID_W'(mark);
                    end
                    in_line[res.rid] = 1'b1;
                    if (q_len == 0)
                        q_head = res.rid;
                    else
                    begin
                        lnk_next[q_tail] = res.rid;
                        lnk_prev[res.rid] = q_tail;
                    end
                    q_tail = res.rid;
                    q_len++;
                    res.ok = 1'b1;
                end
            end
            oqr_pkg::OP_SERVE:
            begin
                if (q_len > 0)
                begin
                    res.rid = q_head;
                    take_out(q_head);
                    give_back(res.rid);
                    res.ok = 1'b1;
                end
            end
            oqr_pkg::OP_REMOVE:
            begin
                if (in_line[r.ticket])
                begin
                    take_out(r.ticket);
                    give_back(r.ticket);
                    res.ok = 1'b1;
                end
            end
            default:
            begin
                if (in_line[r.ticket])
                begin
                    take_out(r.ticket);
                    in_line[r.ticket] = 1'b1;
                    if (q_len == 0)
                        q_tail = r.ticket;
                    else
                    begin
                        lnk_prev[q_head] = r.ticket;
                        lnk_next[r.ticket] = q_head;
                    end
                    q_head = r.ticket;
                    q_len++;
                    res.ok = 1'b1;
                end
            end
        endcase
        res.len = oqr_pkg::CNT_W'(q_len);
        return res;
    endfunction

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    {op, ticket} <= pending_reqs[0];
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycles <= cycles + 1;
            in_taken = in_valid && in_ready;
            if (in_valid && in_ready)
                awaited.push_back(ticket_outcome(pending_reqs.pop_front()));
            if (out_valid && out_ready)
            begin
                if (awaited.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected transaction: ok=%0b id=%0d len=%0d",
                                 ok, result_id, length);
                end
                else
                begin
                    resp_t want;
                    want = awaited.pop_front();
                    if (want.ok !== ok || want.rid !== result_id || want.len !== length)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: expected ok=%0b id=%0d len=%0d,",
                                      " got ok=%0b id=%0d len=%0d"},
                                     want.ok, want.rid, want.len, ok, result_id, length);
                    end
                end
            end
            if (cycles > RUN_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // long receiver hold-off, counted in its own process
    initial
    begin
        recv_hold = 1'b0;
        wait (rst_n);
        repeat (3000) @(posedge clk);
        @(negedge clk);
        recv_hold = 1'b1;
        repeat (300) @(negedge clk);
        recv_hold = 1'b0;
    end

    task automatic queue_req(input oqr_pkg::op_t o, input int t);
        pending_reqs.push_back({o, oqr_pkg::ID_W'(t)});
    endtask

    task automatic drain_pending;
        wait (pending_reqs.size() == 0);
        wait (awaited.size() == 0);
    endtask

    function automatic oqr_pkg::op_t pick_op(input int w_issue);
        int r;
        r = $urandom_range(99);
        if (r < w_issue)
            return oqr_pkg::OP_ISSUE;
        r = $urandom_range(2);
        return oqr_pkg::op_t'(r + 1);
    endfunction

    initial
    begin
        oqr_pkg::op_t o;
        int  t;
        int  phase_items;
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = oqr_pkg::OP_ISSUE;
        ticket = '0;
        out_ready = 1'b0;
        in_taken = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        errors = 0;
        cycles = 0;
        for (int i = 0; i < oqr_pkg::MAX_IDS; i++)
        begin
            lnk_next[i] = '0;
            lnk_prev[i] = '0;
            in_line[i] = 1'b0;
            spare_ids[i] = '0;
        end
        spare_cnt = 0;
        q_head = '0;
        q_tail = '0;
        q_len = 0;
        mark = -1;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty queue cases, then head/tail cases
        queue_req(oqr_pkg::OP_SERVE, 0);
        queue_req(oqr_pkg::OP_REMOVE, 0);
        queue_req(oqr_pkg::OP_MOVE, 1023);
        for (int i = 0; i < 5; i++)
            queue_req(oqr_pkg::OP_ISSUE, 1023);
        queue_req(oqr_pkg::OP_MOVE, 0);      // move of the head
        queue_req(oqr_pkg::OP_MOVE, 4);      // tail to front
        queue_req(oqr_pkg::OP_MOVE, 2);      // middle to front
        queue_req(oqr_pkg::OP_REMOVE, 2);    // remove of the head
        queue_req(oqr_pkg::OP_REMOVE, 3);    // tail
        queue_req(oqr_pkg::OP_REMOVE, 1);    // tail
        queue_req(oqr_pkg::OP_REMOVE, 1);    // no longer queued
        queue_req(oqr_pkg::OP_SERVE, 0);
        queue_req(oqr_pkg::OP_ISSUE, 0);     // recycled IDs, LIFO
        queue_req(oqr_pkg::OP_ISSUE, 0);
        queue_req(oqr_pkg::OP_SERVE, 0);
        queue_req(oqr_pkg::OP_SERVE, 0);
        queue_req(oqr_pkg::OP_SERVE, 0);
        queue_req(oqr_pkg::OP_SERVE, 0);     // empty again
        queue_req(oqr_pkg::OP_REMOVE, 1023);
        drain_pending();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                1: begin send_idle_pct = 53; recv_idle_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_idle_pct = 53; end
                default: begin send_idle_pct = 28; recv_idle_pct = 28; end
            endcase
            phase_items = 255;
            for (int i = 0; i < phase_items; i++)
            begin
                o = pick_op(ph == 1 ? 60 : 35);
                // mostly name IDs that are likely to be out
                if ($urandom_range(9) < 8 && mark >= 0)
                    t = $urandom_range(mark < 1023 ? mark + 1 : 1023);
                else
                    t = $urandom_range(1023);
                queue_req(o, t);
            end
            drain_pending();
            repeat ($urandom_range(20)) @(posedge clk);
        end

        drain_pending();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// ===== ordered_queue_with_id_recycling.f =====
+incdir+rtl/core
rtl/core/oqr_pkg.sv
rtl/core/oqr_ram.sv
rtl/core/oqr_ctrl.sv
rtl/core/oqr_dp.sv
rtl/core/ordered_queue_with_id_recycling.sv
rtl/core/oqr_checker.sv
sim/ordered_queue_with_id_recycling_test.sv
